FILE: design/vbp_pkg.sv
// Shared types and constants for the vector bin-packing server allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package vbp_pkg;

	localparam int SLOTS  = 16;
	localparam int SLOT_W = 4;
	localparam int KINDS  = 4;
	localparam int AMT_W  = 10;
	localparam int TIME_W = 48;
	localparam int DUR_W  = 30;
	localparam int CNT_W  = 5;
	localparam int STAT_W = 3;
	localparam int IN_W   = 128;
	localparam int OUT_W  = 112;

	localparam logic [STAT_W-1:0] ST_PLACED   = 3'd0;
	localparam logic [STAT_W-1:0] ST_OPENED   = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STAT_W-1:0] ST_RELEASED = 3'd3;
	localparam logic [STAT_W-1:0] ST_CLOSED   = 3'd4;
	localparam logic [STAT_W-1:0] ST_BAD_SLOT = 3'd5;

	localparam logic CMD_SCHEDULE = 1'b0;
	localparam logic CMD_RELEASE  = 1'b1;

	localparam logic [AMT_W-1:0] CAP_RESET = 10'd1000;

	typedef logic [KINDS-1:0][AMT_W-1:0] row_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic fetch;
		logic update;
		logic out_load;
	} vbp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_release;
		logic scan_done;
	} vbp_stat_t;

endpackage
`default_nettype wire

FILE: design/vbp_ctrl.sv
// Sequencing state machine of the allocator: accept, scan, fetch, update, output.
// Depends on vbp_pkg for the command and status structs.
`default_nettype none
module vbp_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	input  wire vbp_pkg::vbp_stat_t stat,
	output vbp_pkg::vbp_cmd_t       cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_FETCH = 3'd2;
	localparam logic [2:0] S_UPD   = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       out_valid_q;
	logic       out_free;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign out_free = !out_valid_q || m_tready;

	// Next state and command decode.
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_nx = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.is_release || stat.scan_done) begin
					state_nx = S_FETCH;
				end
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_nx  = S_UPD;
			end
			S_UPD: begin
				cmd.update = 1'b1;
				state_nx   = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// State and output word valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/vbp_dpath.sv
// Datapath of the allocator: slot table, free-amount memory, scan and update logic.
// Depends on vbp_pkg; driven by vbp_ctrl through the command struct.
`default_nettype none
module vbp_dpath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	input  wire logic [vbp_pkg::AMT_W-1:0]     cfg_data,
	input  wire logic                          s_tuser,
	input  wire logic [vbp_pkg::IN_W-1:0]      s_tdata,
	input  wire vbp_pkg::vbp_cmd_t             cmd,
	output vbp_pkg::vbp_stat_t                 stat,
	output logic [vbp_pkg::OUT_W-1:0]          m_tdata,
	output logic [vbp_pkg::STAT_W-1:0]         m_tuser
);

	localparam int SL = vbp_pkg::SLOTS;
	localparam int SW = vbp_pkg::SLOT_W;
	localparam int TW = vbp_pkg::TIME_W;
	localparam int AW = vbp_pkg::AMT_W;
	localparam int KN = vbp_pkg::KINDS;
	localparam int CW = vbp_pkg::CNT_W;

	// Latched input word.
	logic                        cmd_q;
	logic [TW-1:0]               now_q;
	logic [vbp_pkg::DUR_W-1:0]   dur_q;
	vbp_pkg::row_t               need_q;
	logic [SW-1:0]               slot_q;

	// Slot table.
	logic [AW-1:0]  cap_q;
	logic [SL-1:0]  valid_q;
	logic [TW-1:0]  start_q [SL];
	logic [TW-1:0]  end_q [SL];
	logic [CW-1:0]  cnt_q;
	vbp_pkg::row_t  mem [SL];
	vbp_pkg::row_t  rd_q;

	// Scan state.
	logic [CW-1:0]  idx_q;
	logic [SW-1:0]  idx_s1;
	logic           pv_s1;
	logic           found_q;
	logic [SW-1:0]  best_q;
	logic [TW-1:0]  best_end_q;
	logic [SW-1:0]  tgt_q;

	// Result registers.
	logic [vbp_pkg::STAT_W-1:0] res_status_q;
	logic [SW-1:0]              res_slot_q;
	logic [TW-1:0]              res_end_q;
	logic [TW-1:0]              res_span_q;
	logic [vbp_pkg::OUT_W-1:0]  out_data_q;
	logic [vbp_pkg::STAT_W-1:0] out_user_q;

	// Combinational helpers.
	logic           scan_run;
	logic           rd_en;
	logic [SW-1:0]  rd_addr;
	logic [SW-1:0]  time_addr;
	logic [TW-1:0]  cur_start;
	logic [TW-1:0]  cur_end;
	logic [TW:0]    end_sum;
	logic [TW-1:0]  job_end;
	logic           free_any;
	logic [SW-1:0]  free_idx;
	logic           row_fits;
	logic           all_cap;
	vbp_pkg::row_t  row_sub;
	vbp_pkg::row_t  row_new;
	vbp_pkg::row_t  row_add;
	logic           wr_en;
	vbp_pkg::row_t  wr_row;

	assign scan_run  = cmd.scan && (cmd_q == vbp_pkg::CMD_SCHEDULE);
	assign rd_en     = (scan_run && (idx_q != CW'(SL))) || cmd.fetch;
	assign rd_addr   = cmd.scan ? idx_q[SW-1:0] :
		((cmd_q == vbp_pkg::CMD_RELEASE) ? slot_q : best_q);
	assign time_addr = cmd.scan ? idx_s1 : tgt_q;
	assign cur_start = start_q[time_addr];
	assign cur_end   = end_q[time_addr];
	assign end_sum   = {1'b0, now_q} + {{(TW + 1 - vbp_pkg::DUR_W){1'b0}}, dur_q};
	assign job_end   = end_sum[TW] ? {TW{1'b1}} : end_sum[TW-1:0];
	assign free_any  = !(&valid_q);

	assign stat.is_release = (cmd_q == vbp_pkg::CMD_RELEASE);
	assign stat.scan_done  = (idx_q == CW'(SL)) && !pv_s1;

	// Lowest slot that is not in use.
	always_comb begin
		free_idx = '0;
		for (int s = SL - 1; s >= 0; s--) begin
			if (!valid_q[s]) begin
				free_idx = SW'(s);
			end
		end
	end

	// Per-kind arithmetic on the fetched row.
	always_comb begin
		logic [AW:0] sum;
		row_fits = 1'b1;
		all_cap  = 1'b1;
		for (int k = 0; k < KN; k++) begin
			sum        = {1'b0, rd_q[k]} + {1'b0, need_q[k]};
			row_fits   = row_fits && (rd_q[k] >= need_q[k]);
			row_sub[k] = (rd_q[k] > need_q[k]) ? (rd_q[k] - need_q[k]) : '0;
			row_new[k] = (cap_q > need_q[k]) ? (cap_q - need_q[k]) : '0;
			row_add[k] = (sum > {1'b0, cap_q}) ? cap_q : sum[AW-1:0];
			all_cap    = all_cap && (row_add[k] == cap_q);
		end
	end

	// Memory write selection for the update cycle.
	always_comb begin
		wr_en  = 1'b0;
		wr_row = row_sub;
		if (cmd.update) begin
			if (cmd_q == vbp_pkg::CMD_RELEASE) begin
				wr_en  = valid_q[slot_q];
				wr_row = row_add;
			end else if (found_q) begin
				wr_en  = 1'b1;
				wr_row = row_sub;
			end else begin
				wr_en  = free_any;
				wr_row = row_new;
			end
		end
	end

	// Free-amount memory, one row per slot.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[tgt_q] <= wr_row;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Input word capture and payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q     <= s_tuser;
			now_q     <= s_tdata[47:0];
			dur_q     <= s_tdata[77:48];
			need_q[0] <= s_tdata[87:78];
			need_q[1] <= s_tdata[97:88];
			need_q[2] <= s_tdata[107:98];
			need_q[3] <= s_tdata[117:108];
			slot_q    <= s_tdata[121:118];
		end
		if (cmd.scan && pv_s1 && valid_q[idx_s1] && row_fits &&
			(!found_q || cur_end > best_end_q)) begin
			best_q     <= idx_s1;
			best_end_q <= cur_end;
		end
		if (cmd.fetch) begin
			tgt_q <= (cmd_q == vbp_pkg::CMD_RELEASE) ? slot_q :
				(found_q ? best_q : free_idx);
		end
		if (cmd.out_load) begin
			out_user_q <= res_status_q;
			out_data_q <= {7'd0, cnt_q, res_span_q, res_end_q, res_slot_q};
		end
	end

	// Slot table, configuration and scan control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q        <= vbp_pkg::CAP_RESET;
			valid_q      <= '0;
			cnt_q        <= '0;
			idx_q        <= '0;
			pv_s1        <= 1'b0;
			idx_s1       <= '0;
			found_q      <= 1'b0;
			res_status_q <= vbp_pkg::ST_PLACED;
			res_slot_q   <= '0;
			res_end_q    <= '0;
			res_span_q   <= '0;
			for (int s = 0; s < SL; s++) begin
				start_q[s] <= {TW{1'b1}};
				end_q[s]   <= '0;
			end
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (cmd.load) begin
				idx_q   <= '0;
				pv_s1   <= 1'b0;
				found_q <= 1'b0;
			end
			// Scan: read one row per cycle and judge it in the next cycle.
			if (scan_run) begin
				if (idx_q != CW'(SL)) begin
					idx_q  <= idx_q + 1'b1;
					idx_s1 <= idx_q[SW-1:0];
					pv_s1  <= 1'b1;
				end else begin
					pv_s1 <= 1'b0;
				end
				if (pv_s1 && valid_q[idx_s1] && row_fits) begin
					found_q <= 1'b1;
				end
			end
			// Apply the command to the chosen slot.
			if (cmd.update) begin
				res_end_q  <= '0;
				res_span_q <= '0;
				res_slot_q <= tgt_q;
				if (cmd_q == vbp_pkg::CMD_RELEASE) begin
					if (!valid_q[slot_q]) begin
						res_status_q <= vbp_pkg::ST_BAD_SLOT;
					end else if ((cur_end <= now_q) && all_cap) begin
						res_status_q    <= vbp_pkg::ST_CLOSED;
						res_span_q      <= (cur_end >= cur_start) ? (cur_end - cur_start) : '0;
						valid_q[tgt_q]  <= 1'b0;
						start_q[tgt_q]  <= {TW{1'b1}};
						end_q[tgt_q]    <= '0;
						cnt_q           <= cnt_q - 1'b1;
					end else begin
						res_status_q <= vbp_pkg::ST_RELEASED;
					end
				end else if (found_q) begin
					res_status_q <= vbp_pkg::ST_PLACED;
					res_end_q    <= job_end;
					if (now_q < cur_start) begin
						start_q[tgt_q] <= now_q;
					end
					if (job_end > cur_end) begin
						end_q[tgt_q] <= job_end;
					end
				end else if (free_any) begin
					res_status_q   <= vbp_pkg::ST_OPENED;
					res_end_q      <= job_end;
					valid_q[tgt_q] <= 1'b1;
					start_q[tgt_q] <= now_q;
					end_q[tgt_q]   <= job_end;
					cnt_q          <= cnt_q + 1'b1;
				end else begin
					res_status_q <= vbp_pkg::ST_FULL;
					res_slot_q   <= '0;
				end
			end
		end
	end

	assign m_tdata = out_data_q;
	assign m_tuser = out_user_q;

	// The server count always matches the number of slots in use.
	a_cnt_match: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == CW'($countones(valid_q)))
		else $error("active server count differs from valid slots");

	// A closed slot is no longer in use when its result is sent.
	a_closed_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && res_status_q == vbp_pkg::ST_CLOSED) |-> !valid_q[res_slot_q])
		else $error("closed slot still valid");

	// A placement or opening always lands on a slot in use.
	a_placed_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && (res_status_q == vbp_pkg::ST_PLACED ||
			res_status_q == vbp_pkg::ST_OPENED)) |-> valid_q[res_slot_q])
		else $error("job placed on a slot not in use");

endmodule
`default_nettype wire

FILE: design/vector_bin_packing_server_allocator_unit.sv
// Vector bin-packing server allocator, top level.
// Joins vbp_ctrl and vbp_dpath; types and constants come from vbp_pkg.
//
// Use: one input word on the s_ channel is either a schedule or a release
// command (s_tuser). Each word yields exactly one result word on the m_
// channel, whose tuser carries the status code. The cfg_ channel writes the
// per-kind capacity of newly opened servers; it is always ready and should
// be written only while no word is in flight.
// Sequence: a schedule word passes from acceptance through a scan that
// reads one free-amount row per cycle over all 16 slots, then through the
// fetch and update steps to the result. A release word skips the scan. One word
// is handled at a time; s_tready is high only while the block is waiting
// for work, and it may be high while a finished result still waits in the
// output register.
// Reset: all slots are free, the capacity is 1000, no output word is valid.
// When the receiver stalls, the result word holds on m_ until it is taken,
// and a next finished word waits in the block until the register frees up.
`default_nettype none
module vector_bin_packing_server_allocator_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [vbp_pkg::AMT_W-1:0]         cfg_data,   // capacity_per_resource
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// now_time, duration, need_0, need_1, need_2, need_3, server_slot
	input  wire logic [vbp_pkg::IN_W-1:0]          s_tdata,
	input  wire logic                              s_tuser,    // command
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// chosen_slot, job_end_time, busy_span, active_servers
	output logic [vbp_pkg::OUT_W-1:0]              m_tdata,
	output logic [vbp_pkg::STAT_W-1:0]             m_tuser     // status
);

	vbp_pkg::vbp_cmd_t  cmd;
	vbp_pkg::vbp_stat_t stat;

	assign cfg_ready = 1'b1;

	vbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	vbp_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the vector bin-packing server allocator.
// Drives schedule and release words, predicts each result word; needs vbp_pkg and the top level.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

	typedef struct packed {
		logic [vbp_pkg::STAT_W-1:0] status;
		logic [vbp_pkg::SLOT_W-1:0] slot;
		logic [vbp_pkg::TIME_W-1:0] job_end;
		logic [vbp_pkg::TIME_W-1:0] span;
		logic [vbp_pkg::CNT_W-1:0]  active;
	} alloc_result_t;

	typedef struct packed {
		logic                       cmd;
		logic [vbp_pkg::TIME_W-1:0] now;
		logic [vbp_pkg::DUR_W-1:0]  dur;
		vbp_pkg::row_t              need;
		logic [vbp_pkg::SLOT_W-1:0] slot;
		logic                       typed;
		logic [vbp_pkg::STAT_W-1:0] typed_status;
	} stim_row_t;

	typedef struct packed {
		logic [vbp_pkg::SLOT_W-1:0] slot;
		vbp_pkg::row_t              need;
	} placed_job_t;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 30;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [vbp_pkg::AMT_W-1:0]     cfg_data = '0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [vbp_pkg::IN_W-1:0]      s_tdata = '0;
	logic                          s_tuser = 1'b0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [vbp_pkg::OUT_W-1:0]     m_tdata;
	logic [vbp_pkg::STAT_W-1:0]    m_tuser;

	// Mirror of the slot table.
	logic [vbp_pkg::AMT_W-1:0]     capacity;
	logic                          slot_live [vbp_pkg::SLOTS];
	logic [vbp_pkg::TIME_W-1:0]    slot_first [vbp_pkg::SLOTS];
	logic [vbp_pkg::TIME_W-1:0]    slot_last [vbp_pkg::SLOTS];
	vbp_pkg::row_t                 slot_free [vbp_pkg::SLOTS];
	int unsigned                   live_count;

	alloc_result_t                 pending_results [$];
	placed_job_t                   running_jobs [$];
	stim_row_t                     directed_rows [$];
	int unsigned                   mismatch_count = 0;
	int unsigned                   quiet_cycles = 0;
	int unsigned                   burst_left = 0;
	logic [vbp_pkg::TIME_W-1:0]    clock_now = 48'd1000;

	vector_bin_packing_server_allocator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [vbp_pkg::TIME_W-1:0] got,
			input logic [vbp_pkg::TIME_W-1:0] want);
		mismatch_count++;
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
	endtask

	// Appends one row to the directed table.
	task automatic add_row(input stim_row_t row);
		directed_rows = {directed_rows, row};
	endtask

	// Computes one result word and advances the mirrored slot table.
	function automatic alloc_result_t allocate_or_release(input logic cmd,
			input logic [vbp_pkg::TIME_W-1:0] now, input logic [vbp_pkg::DUR_W-1:0] dur,
			input vbp_pkg::row_t need, input logic [vbp_pkg::SLOT_W-1:0] slot);
		alloc_result_t res;
		logic [vbp_pkg::TIME_W:0] sum;
		logic [vbp_pkg::TIME_W-1:0] job_end;
		logic found;
		logic fit;
		int best;
		int open_slot;
		logic [vbp_pkg::AMT_W:0] back;
		res = '0;
		found = 1'b0;
		best = 0;
		open_slot = -1;
		if (cmd == vbp_pkg::CMD_SCHEDULE) begin
			sum = now + dur;
			job_end = sum[vbp_pkg::TIME_W] ? '1 : sum[vbp_pkg::TIME_W-1:0];
			// Best fit is the live slot with the latest end time, lowest slot on ties.
			for (int s = 0; s < vbp_pkg::SLOTS; s++) begin
				fit = 1'b1;
				for (int k = 0; k < vbp_pkg::KINDS; k++)
					if (slot_free[s][k] < need[k])
						fit = 1'b0;
				if (slot_live[s] && fit && (!found || slot_last[s] > slot_last[best])) begin
					best = s;
					found = 1'b1;
				end
				if (!slot_live[s] && open_slot < 0)
					open_slot = s;
			end
			if (found) begin
				res.status = vbp_pkg::ST_PLACED;
			end else if (open_slot >= 0) begin
				best = open_slot;
				found = 1'b1;
				res.status = vbp_pkg::ST_OPENED;
				slot_live[best] = 1'b1;
				slot_first[best] = '1;
				slot_last[best] = '0;
				for (int k = 0; k < vbp_pkg::KINDS; k++)
					slot_free[best][k] = capacity;
				live_count++;
			end else begin
				res.status = vbp_pkg::ST_FULL;
			end
			if (found) begin
				if (now < slot_first[best])
					slot_first[best] = now;
				if (job_end > slot_last[best])
					slot_last[best] = job_end;
				for (int k = 0; k < vbp_pkg::KINDS; k++)
					slot_free[best][k] = (slot_free[best][k] > need[k]) ?
						slot_free[best][k] - need[k] : '0;
				res.slot = vbp_pkg::SLOT_W'(best);
				res.job_end = job_end;
			end
		end else begin
			res.slot = slot;
			if (!slot_live[slot]) begin
				res.status = vbp_pkg::ST_BAD_SLOT;
			end else begin
				fit = 1'b1;
				for (int k = 0; k < vbp_pkg::KINDS; k++) begin
					back = slot_free[slot][k] + need[k];
					slot_free[slot][k] = (back > capacity) ? capacity :
						back[vbp_pkg::AMT_W-1:0];
					if (slot_free[slot][k] != capacity)
						fit = 1'b0;
				end
				// The server closes once idle and past its end time.
				if (slot_last[slot] <= now && fit) begin
					if (slot_last[slot] >= slot_first[slot])
						res.span = slot_last[slot] - slot_first[slot];
					slot_live[slot] = 1'b0;
					slot_first[slot] = '1;
					slot_last[slot] = '0;
					if (live_count > 0)
						live_count--;
					res.status = vbp_pkg::ST_CLOSED;
				end else begin
					res.status = vbp_pkg::ST_RELEASED;
				end
			end
		end
		res.active = vbp_pkg::CNT_W'(live_count);
		return res;
	endfunction

	// Predicts, then offers one word and waits until it is taken.
	task automatic send_word(input stim_row_t row);
		alloc_result_t res;
		res = allocate_or_release(row.cmd, row.now, row.dur, row.need, row.slot);
		if (row.typed && res.status != row.typed_status)
			report_mismatch("table status", res.status, row.typed_status);
		pending_results = {pending_results, res};
		if (row.cmd == vbp_pkg::CMD_SCHEDULE &&
			(res.status == vbp_pkg::ST_PLACED || res.status == vbp_pkg::ST_OPENED))
			running_jobs = {running_jobs, placed_job_t'{slot: res.slot, need: row.need}};
		s_tvalid <= 1'b1;
		s_tuser <= row.cmd;
		s_tdata <= {6'b0, row.slot, row.need, row.dur, row.now};
		do @(posedge clk); while (!s_tready);
		// Bursts of words with random gaps between them.
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [vbp_pkg::AMT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		capacity = value;
	endtask

	function automatic vbp_pkg::row_t random_need(input logic [vbp_pkg::AMT_W-1:0] cap);
		vbp_pkg::row_t need;
		for (int k = 0; k < vbp_pkg::KINDS; k++)
			case ($urandom_range(0, 5))
				0: need[k] = vbp_pkg::AMT_W'($urandom_range(0, 1023));
				1: need[k] = '0;
				default: need[k] = vbp_pkg::AMT_W'($urandom_range(0, (cap / 3) + 1));
			endcase
		return need;
	endfunction

	function automatic stim_row_t random_row();
		stim_row_t row;
		int idx;
		row = '0;
		// Time mostly moves forward; now and then it jumps anywhere.
		case ($urandom_range(0, 40))
			0: clock_now = vbp_pkg::TIME_W'({$urandom, $urandom});
			1: clock_now = 48'hFFFF_FFFF_FFFF - $urandom_range(0, 5000);
			2: clock_now = vbp_pkg::TIME_W'($urandom_range(0, 100));
			default: clock_now = clock_now + $urandom_range(0, 1500);
		endcase
		row.now = clock_now;
		row.dur = ($urandom_range(0, 15) == 0) ? vbp_pkg::DUR_W'($urandom) :
			vbp_pkg::DUR_W'($urandom_range(0, 3000));
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				row.cmd = vbp_pkg::CMD_SCHEDULE;
				row.need = random_need(capacity);
			end
			4, 5, 6, 7, 8: begin
				// Release a job that is still running, with its own needs.
				row.cmd = vbp_pkg::CMD_RELEASE;
				if (running_jobs.size() != 0) begin
					idx = $urandom_range(0, running_jobs.size() - 1);
					row.slot = running_jobs[idx].slot;
					row.need = running_jobs[idx].need;
					running_jobs.delete(idx);
				end else begin
					row.slot = vbp_pkg::SLOT_W'($urandom);
				end
			end
			default: begin
				// Stray release: any slot, any amounts.
				row.cmd = vbp_pkg::CMD_RELEASE;
				row.slot = vbp_pkg::SLOT_W'($urandom);
				row.need = random_need(10'd1023);
				row.dur = vbp_pkg::DUR_W'($urandom);
			end
		endcase
		return row;
	endfunction

	// Receiver stalls in stretches: always ready, random, or mostly stalled.
	int unsigned stall_left = 0;
	int unsigned stall_mode = 0;
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(5, 80);
		end
		stall_left--;
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Compare each result word with the oldest prediction.
	alloc_result_t want;
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result word", '0, '0);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser != want.status)
					report_mismatch("status", m_tuser, want.status);
				if (m_tdata[3:0] != want.slot)
					report_mismatch("chosen_slot", m_tdata[3:0], want.slot);
				if (m_tdata[51:4] != want.job_end)
					report_mismatch("job_end_time", m_tdata[51:4], want.job_end);
				if (m_tdata[99:52] != want.span)
					report_mismatch("busy_span", m_tdata[99:52], want.span);
				if (m_tdata[104:100] != want.active)
					report_mismatch("active_servers", m_tdata[104:100], want.active);
			end
		end
	end

	// Watchdog on cycles with no handshake at all.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		logic [vbp_pkg::AMT_W-1:0] phase_caps [5];
		capacity = vbp_pkg::CAP_RESET;
		live_count = 0;
		for (int s = 0; s < vbp_pkg::SLOTS; s++) begin
			slot_live[s] = 1'b0;
			slot_first[s] = '1;
			slot_last[s] = '0;
			slot_free[s] = '0;
		end
		phase_caps = '{vbp_pkg::CAP_RESET, 10'd1, 10'd1023, 10'd0, vbp_pkg::CAP_RESET};
		phase_caps[3] = vbp_pkg::AMT_W'($urandom_range(2, 1022));

		// Directed table: empty table, saturation, oversize jobs, stray releases, a full table.
		add_row('{vbp_pkg::CMD_RELEASE, 48'd5, 30'd0, '0, 4'd0, 1'b1, vbp_pkg::ST_BAD_SLOT});
		add_row('{vbp_pkg::CMD_SCHEDULE, 48'd100, 30'd50, {4{10'd10}}, 4'd0, 1'b1,
			vbp_pkg::ST_OPENED});
		add_row('{vbp_pkg::CMD_SCHEDULE, 48'd0, 30'h3FFF_FFFF, {4{10'd1023}}, 4'd0,
			1'b1, vbp_pkg::ST_OPENED});
		add_row('{vbp_pkg::CMD_SCHEDULE, 48'hFFFF_FFFF_FFFF, 30'h3FFF_FFFF, '0, 4'd0,
			1'b1, vbp_pkg::ST_PLACED});
		add_row('{vbp_pkg::CMD_RELEASE, 48'd7, 30'd0, '0, 4'd15, 1'b1, vbp_pkg::ST_BAD_SLOT});
		add_row('{vbp_pkg::CMD_RELEASE, 48'hFFFF_FFFF_FFFF, 30'd0, {4{10'd1023}}, 4'd1,
			1'b0, vbp_pkg::ST_PLACED});
		add_row('{vbp_pkg::CMD_RELEASE, 48'hFFFF_FFFF_FFFF, 30'd0, {4{10'd1023}}, 4'd0,
			1'b0, vbp_pkg::ST_PLACED});
		for (int i = 0; i < 17; i++)
			add_row('{vbp_pkg::CMD_SCHEDULE, 48'd200 + i, 30'd100, {10'd1023, 30'd0},
				4'd0, 1'b0, vbp_pkg::ST_PLACED});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_word(directed_rows[i]);

		// Random phases, each under its own capacity; the results drain in between.
		for (int p = 0; p < 5; p++) begin
			drain_results();
			if (p != 0)
				write_capacity(phase_caps[p]);
			for (int n = 0; n < 380; n++) begin
				row = random_row();
				send_word(row);
			end
		end

		drain_results();
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire
